// File: rtl/rmlt_pkg.sv
// rename map line tokenizer: shared types and constants
// beat structs for the byte and result channels, event codes, field widths
// no dependencies
package rmlt_pkg;

    // field widths
    localparam int CH_W    = 8;
    localparam int EV_W    = 3;
    localparam int LINE_W  = 11;
    localparam int OFF_W   = 10;
    localparam int CFG_W   = 10;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    // defaults and limits
    localparam int BUFFER_LIMIT_DEF = 1024;
    localparam logic [CFG_W-1:0]  MAX_SYM_RESET = 10'd127;
    localparam logic [LINE_W-1:0] LINE_FIRST    = 11'd1;
    localparam logic [LINE_W-1:0] LINE_SAT      = 11'd2047;

    // register index
    localparam logic REG_MAX_SYMBOL_LENGTH = 1'b0;

    // character codes
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CH_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CH_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CH_W-1:0] CH_UNDER   = 8'h5F;
    localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0A;

    // result event codes
    typedef enum logic [EV_W-1:0] {
        EV_NONE        = 3'd0,
        EV_ENTRY       = 3'd1,
        EV_MISSING_VAL = 3'd2,
        EV_KEY_LONG    = 3'd3,
        EV_VALUE_LONG  = 3'd4,
        EV_OVERFLOW    = 3'd5
    } event_t;

    // input beat
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            first;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [LINE_W-1:0] line_number;
        logic [OFF_W-1:0]  key_begin;
        logic [OFF_W-1:0]  key_stop;
        logic [OFF_W-1:0]  value_begin;
        logic [OFF_W-1:0]  value_stop;
        logic              halted;
    } out_beat_t;

endpackage

// File: rtl/rename_map_line_tokenizer_unit.sv
// rename map line tokenizer: top level, scanner state and result register
// depends on rmlt_pkg for beat structs, event codes and widths
// one module: byte scanner, length checks, apb register, output register
//
// a result beat is registered and becomes valid in the cycle after its byte beat is taken
// throughput: one byte per cycle while the result channel is not stalled; the scanner state
//   updates in the cycle the byte is taken and the result register frees as the result beat is taken
// reset: synchronous active-low aresetn clears scanner state, halt and the
//   result valid flag, and sets max_symbol_length to 127
module rename_map_line_tokenizer_unit #(
    parameter int BUFFER_LIMIT = rmlt_pkg::BUFFER_LIMIT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // byte channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  rmlt_pkg::in_beat_t           s_data,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output rmlt_pkg::out_beat_t          m_data,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rmlt_pkg::PADDR_W-1:0] paddr,
    input  logic [rmlt_pkg::APB_W-1:0]   pwdata,
    output logic [rmlt_pkg::APB_W-1:0]   prdata,
    output logic                         pready
);
    import rmlt_pkg::*;

    localparam int POS_W = (BUFFER_LIMIT > 2) ? $clog2(BUFFER_LIMIT) : 1;
    localparam int LEN_W = (POS_W > OFF_W) ? POS_W : OFF_W;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_LIMIT - 1);

    typedef enum logic [2:0] {
        SCAN_KEY_START   = 3'd0,
        SCAN_KEY_END     = 3'd1,
        SCAN_VALUE_START = 3'd2,
        SCAN_VALUE_END   = 3'd3,
        SCAN_LINE_END    = 3'd4
    } scan_t;

    // scanner state
    scan_t             scan_reg,        scan_next;
    logic [POS_W-1:0]  pos_reg,         pos_next;
    logic [LINE_W-1:0] line_reg,        line_next;
    logic [POS_W-1:0]  key_first_reg,   key_first_next;
    logic [POS_W-1:0]  key_past_reg,    key_past_next;
    logic [POS_W-1:0]  value_first_reg, value_first_next;
    logic              stopped_reg,     stopped_next;
    logic [CFG_W-1:0]  max_sym_reg;

    // result register
    logic      m_valid_reg;
    out_beat_t m_data_reg, m_data_next;

    // view of the state after an optional restart
    scan_t             scan_cur;
    logic [POS_W-1:0]  pos_cur, key_first_cur, key_past_cur, value_first_cur;
    logic [LINE_W-1:0] line_cur;
    logic              stopped_cur;

    logic            take;
    logic            nl, letter, ident;
    logic [CH_W-1:0] ch;
    event_t          ev;
    event_t          finish_ev;
    logic [LEN_W-1:0] key_len, value_len, max_len;
    logic [LEN_W-1:0] kf_ext, kp_ext, vf_ext, pos_ext;

    assign take    = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // byte classes
    assign ch     = s_data.ch;
    assign nl     = (ch == CH_NEWLINE);
    assign letter = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
                    (ch >= CH_LOWER_A && ch <= CH_LOWER_Z);
    assign ident  = letter || (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) ||
                    (ch == CH_UNDER);

    // restart before the byte when it is marked first
    always_comb begin
        if (s_data.first) begin
            scan_cur        = SCAN_KEY_START;
            pos_cur         = '0;
            line_cur        = LINE_FIRST;
            key_first_cur   = '0;
            key_past_cur    = '0;
            value_first_cur = '0;
            stopped_cur     = 1'b0;
        end else begin
            scan_cur        = scan_reg;
            pos_cur         = pos_reg;
            line_cur        = line_reg;
            key_first_cur   = key_first_reg;
            key_past_cur    = key_past_reg;
            value_first_cur = value_first_reg;
            stopped_cur     = stopped_reg;
        end
    end

    // entry length checks
    assign kf_ext    = LEN_W'(key_first_cur);
    assign kp_ext    = LEN_W'(key_past_cur);
    assign vf_ext    = LEN_W'(value_first_cur);
    assign pos_ext   = LEN_W'(pos_cur);
    assign key_len   = kp_ext - kf_ext;
    assign value_len = pos_ext - vf_ext;
    assign max_len   = LEN_W'(max_sym_reg);

    always_comb begin
        if (key_len > max_len) begin
            finish_ev = EV_KEY_LONG;
        end else if (value_len > max_len) begin
            finish_ev = EV_VALUE_LONG;
        end else begin
            finish_ev = EV_ENTRY;
        end
    end

    // scanner step
    always_comb begin
        scan_next        = scan_cur;
        pos_next         = pos_cur;
        line_next        = line_cur;
        key_first_next   = key_first_cur;
        key_past_next    = key_past_cur;
        value_first_next = value_first_cur;
        stopped_next     = stopped_cur;
        ev               = EV_NONE;
        if (!stopped_cur) begin
            if (pos_cur >= POS_LAST) begin
                ev           = EV_OVERFLOW;
                stopped_next = 1'b1;
            end else begin
                case (scan_cur)
                    SCAN_KEY_START: begin
                        if (letter) begin
                            key_first_next = pos_cur;
                            scan_next      = SCAN_KEY_END;
                        end
                    end
                    SCAN_KEY_END: begin
                        if (nl) begin
                            ev = EV_MISSING_VAL;
                        end else if (!ident) begin
                            key_past_next = pos_cur;
                            scan_next     = SCAN_VALUE_START;
                        end
                    end
                    SCAN_VALUE_START: begin
                        if (nl) begin
                            ev = EV_MISSING_VAL;
                        end else if (letter) begin
                            value_first_next = pos_cur;
                            scan_next        = SCAN_VALUE_END;
                        end
                    end
                    SCAN_VALUE_END: begin
                        if (nl || !ident) begin
                            ev        = finish_ev;
                            scan_next = nl ? SCAN_KEY_START : SCAN_LINE_END;
                            if (finish_ev != EV_ENTRY) begin
                                stopped_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (nl) begin
                            scan_next = SCAN_KEY_START;
                        end
                    end
                endcase
                if (nl && line_cur != LINE_SAT) begin
                    line_next = line_cur + 1'b1;
                end
                pos_next = pos_cur + 1'b1;
            end
        end
    end

    // result beat contents
    always_comb begin
        m_data_next             = '0;
        m_data_next.event_res   = ev;
        m_data_next.line_number = line_cur;
        m_data_next.halted      = stopped_next;
        if (ev == EV_ENTRY || ev == EV_KEY_LONG || ev == EV_VALUE_LONG) begin
            m_data_next.key_begin   = kf_ext[OFF_W-1:0];
            m_data_next.key_stop    = kp_ext[OFF_W-1:0];
            m_data_next.value_begin = vf_ext[OFF_W-1:0];
            m_data_next.value_stop  = pos_ext[OFF_W-1:0];
        end
    end

    // scanner state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg        <= SCAN_KEY_START;
            pos_reg         <= '0;
            line_reg        <= LINE_FIRST;
            key_first_reg   <= '0;
            key_past_reg    <= '0;
            value_first_reg <= '0;
            stopped_reg     <= 1'b0;
        end else if (take) begin
            scan_reg        <= scan_next;
            pos_reg         <= pos_next;
            line_reg        <= line_next;
            key_first_reg   <= key_first_next;
            key_past_reg    <= key_past_next;
            value_first_reg <= value_first_next;
            stopped_reg     <= stopped_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= m_data_next;
        end
    end

    // apb register
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_sym_reg <= MAX_SYM_RESET;
        end else if (psel && penable && pwrite &&
                     paddr[PADDR_W-1] == REG_MAX_SYMBOL_LENGTH) begin
            max_sym_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_MAX_SYMBOL_LENGTH) begin
            prdata = APB_W'(max_sym_reg);
        end
    end

`ifndef SYNTHESIS
    // a fatal event always leaves the block halted
    a_fatal_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_res == EV_KEY_LONG ||
                    m_data.event_res == EV_VALUE_LONG ||
                    m_data.event_res == EV_OVERFLOW) |-> m_data.halted)
        else $error("fatal event without halt");

    // a good entry never comes from a halted scanner
    a_entry_live: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_res == EV_ENTRY |-> !m_data.halted)
        else $error("entry reported while halted");

    // a halted scanner does not advance on an unmarked byte
    a_halt_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        take && stopped_reg && !s_data.first |=> $stable(pos_reg) && stopped_reg)
        else $error("halted scanner advanced");

    // offsets are zero unless an entry finished
    a_offsets_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_res == EV_NONE ||
                    m_data.event_res == EV_MISSING_VAL ||
                    m_data.event_res == EV_OVERFLOW)
        |-> m_data.key_begin == '0 && m_data.value_stop == '0)
        else $error("offsets on a non-entry event");

    // on a finished entry the key and the value each end after they start
    a_key_order: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !stopped_cur && scan_cur == SCAN_VALUE_END && (nl || !ident)
        |-> key_past_cur > key_first_cur && pos_cur > value_first_cur)
        else $error("entry offsets out of order");
`endif

endmodule

// File: bench/rename_map_line_tokenizer_unit_test.sv
// self-checking bench for the rename map line tokenizer unit
// drives byte beats and register writes, predicts every result beat and checks it
// depends on rmlt_pkg and rename_map_line_tokenizer_unit
module rename_map_line_tokenizer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rmlt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AFTER  = 700;
    localparam int HOLD_CYCLES = 400;
    localparam int REPORT_MAX  = 10;

    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_EQUALS = 8'h3D;

    typedef enum logic [2:0] {
        SCAN_KEY_START,
        SCAN_KEY_END,
        SCAN_VALUE_START,
        SCAN_VALUE_END,
        SCAN_LINE_END
    } scan_phase_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    // clock, reset and block ports
    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_beat_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_beat_t          m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [APB_W-1:0]   pwdata  = '0;
    logic [APB_W-1:0]   prdata;
    logic               pready;

    // tokenizer state as the bench sees it
    logic [CFG_W-1:0] max_symbol_limit = MAX_SYM_RESET;
    scan_phase_t      tok_phase        = SCAN_KEY_START;
    int               tok_offset       = 0;
    logic [LINE_W-1:0] tok_line        = LINE_FIRST;
    int               tok_key_first    = 0;
    int               tok_key_past     = 0;
    int               tok_value_first  = 0;
    bit               tok_halted       = 1'b0;

    // byte beats waiting to go out and result beats still owed by the block
    in_beat_t  bytes_to_send[$];
    out_beat_t scan_results_due[$];

    int       mismatch_count  = 0;
    int       results_checked = 0;
    int       cycle_count     = 0;
    int       bytes_pushed    = 0;
    bit       mark_first      = 1'b0;
    bit       restarts_on     = 1'b1;
    int       burst_left      = 0;
    int       gap_left        = 0;
    int       hold_left       = 0;
    bit       hold_done       = 1'b0;
    int       rx_left         = 0;
    rx_mode_t rx_mode         = RX_OPEN;

    rename_map_line_tokenizer_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_letter(input logic [CH_W-1:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic bit is_ident(input logic [CH_W-1:0] c);
        return is_letter(c) || (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || c == CH_UNDER;
    endfunction

    // advance the tokenizer by one byte and return the result beat it owes
    function automatic out_beat_t scan_byte(input in_beat_t b);
        event_t            ev;
        int                pos_now;
        int                key_len;
        int                val_len;
        logic [LINE_W-1:0] line_now;
        bit                nl;
        out_beat_t         r;
        ev = EV_NONE;
        nl = (b.ch == CH_NEWLINE);
        if (b.first) begin
            tok_phase       = SCAN_KEY_START;
            tok_offset      = 0;
            tok_line        = LINE_FIRST;
            tok_key_first   = 0;
            tok_key_past    = 0;
            tok_value_first = 0;
            tok_halted      = 1'b0;
        end
        pos_now  = tok_offset;
        line_now = tok_line;
        if (!tok_halted) begin
            if (pos_now >= BUFFER_LIMIT_DEF - 1) begin
                // last buffer slot is never scanned
                ev = EV_OVERFLOW;
                tok_halted = 1'b1;
            end else begin
                case (tok_phase)
                    SCAN_KEY_START: begin
                        if (is_letter(b.ch)) begin
                            tok_key_first = pos_now;
                            tok_phase = SCAN_KEY_END;
                        end
                    end
                    SCAN_KEY_END: begin
                        if (nl) begin
                            ev = EV_MISSING_VAL;
                        end else if (!is_ident(b.ch)) begin
                            tok_key_past = pos_now;
                            tok_phase = SCAN_VALUE_START;
                        end
                    end
                    SCAN_VALUE_START: begin
                        if (nl) begin
                            ev = EV_MISSING_VAL;
                        end else if (is_letter(b.ch)) begin
                            tok_value_first = pos_now;
                            tok_phase = SCAN_VALUE_END;
                        end
                    end
                    SCAN_VALUE_END: begin
                        if (nl || !is_ident(b.ch)) begin
                            // entry done: key length wins over value length
                            key_len = tok_key_past - tok_key_first;
                            val_len = pos_now - tok_value_first;
                            if (key_len > max_symbol_limit) begin
                                ev = EV_KEY_LONG;
                                tok_halted = 1'b1;
                            end else if (val_len > max_symbol_limit) begin
                                ev = EV_VALUE_LONG;
                                tok_halted = 1'b1;
                            end else begin
                                ev = EV_ENTRY;
                            end
                            tok_phase = nl ? SCAN_KEY_START : SCAN_LINE_END;
                        end
                    end
                    default: begin
                        if (nl) tok_phase = SCAN_KEY_START;
                    end
                endcase
                if (nl && tok_line < LINE_SAT) tok_line = tok_line + 1'b1;
                tok_offset = pos_now + 1;
            end
        end
        r = '0;
        r.event_res   = ev;
        r.line_number = line_now;
        r.halted      = tok_halted;
        if (ev == EV_ENTRY || ev == EV_KEY_LONG || ev == EV_VALUE_LONG) begin
            r.key_begin   = OFF_W'(tok_key_first);
            r.key_stop    = OFF_W'(tok_key_past);
            r.value_begin = OFF_W'(tok_value_first);
            r.value_stop  = OFF_W'(pos_now);
        end
        return r;
    endfunction

    function automatic string fmt_result(input out_beat_t r);
        return $sformatf("ev=%0d line=%0d key=%0d..%0d value=%0d..%0d halted=%0d",
                         r.event_res, r.line_number, r.key_begin, r.key_stop,
                         r.value_begin, r.value_stop, r.halted);
    endfunction

    task automatic flag_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) $display("MISMATCH: %s", msg);
    endtask

    // byte driver: bursts of beats with random gaps, predicts on every accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) scan_results_due.push_back(scan_byte(s_data));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (bytes_to_send.size() > 0) begin
                    s_data  <= bytes_to_send.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: every result beat against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (scan_results_due.size() == 0) begin
                flag_failure({"unexpected result beat: ", fmt_result(m_data)});
            end else begin
                out_beat_t want;
                want = scan_results_due.pop_front();
                if (m_data.event_res !== want.event_res || m_data.line_number !== want.line_number
                    || m_data.key_begin !== want.key_begin || m_data.key_stop !== want.key_stop
                    || m_data.value_begin !== want.value_begin
                    || m_data.value_stop !== want.value_stop || m_data.halted !== want.halted)
                    flag_failure($sformatf("result %0d expected %s got %s", results_checked,
                                           fmt_result(want), fmt_result(m_data)));
            end
        end
    end

    // result receiver: stall patterns per segment, plus one long hold-off
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!hold_done && results_checked >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_left = $urandom_range(16, 128);
                end
                rx_left--;
                case (rx_mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_byte(input logic [CH_W-1:0] c);
        in_beat_t b;
        b.ch    = c;
        b.first = mark_first;
        mark_first = 1'b0;
        bytes_to_send.push_back(b);
        bytes_pushed++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    function automatic logic [CH_W-1:0] rand_letter();
        return $urandom_range(0, 1) ? CH_W'(CH_UPPER_A + $urandom_range(0, 25))
                                    : CH_W'(CH_LOWER_A + $urandom_range(0, 25));
    endfunction

    function automatic logic [CH_W-1:0] rand_ident_char();
        case ($urandom_range(0, 3))
            0, 1:    return rand_letter();
            2:       return CH_W'(CH_DIGIT_0 + $urandom_range(0, 9));
            default: return CH_UNDER;
        endcase
    endfunction

    // any byte that ends a symbol but not a line
    function automatic logic [CH_W-1:0] rand_separator();
        logic [CH_W-1:0] c;
        case ($urandom_range(0, 4))
            0: c = CH_SPACE;
            1: c = CH_TAB;
            2: c = CH_EQUALS;
            3: c = CH_W'($urandom_range(128, 255));
            default: begin
                do c = CH_W'($urandom_range(0, 255));
                while (is_ident(c) || c == CH_NEWLINE);
            end
        endcase
        return c;
    endfunction

    // symbol length, mostly short, sometimes at or just over the limit
    function automatic int pick_len(input int lim);
        int len;
        len = $urandom_range(1, (lim < 10) ? lim + 2 : 10);
        if (lim <= 20 && $urandom_range(0, 5) == 0) len = lim + $urandom_range(0, 1);
        return len;
    endfunction

    // one line: mostly key, separators, value; some missing values and junk lines
    task automatic push_line(input int lim);
        int klen;
        int vlen;
        int kind;
        kind = $urandom_range(0, 9);
        if (restarts_on && $urandom_range(0, 39) == 0) mark_first = 1'b1;
        if ($urandom_range(0, 4) == 0) push_byte(rand_separator());
        if (kind == 1) begin
            repeat ($urandom_range(1, 6)) push_byte(CH_W'($urandom_range(0, 255)));
            push_byte(CH_NEWLINE);
        end else begin
            klen = pick_len(lim);
            vlen = pick_len(lim);
            push_byte(rand_letter());
            repeat (klen - 1) push_byte(rand_ident_char());
            if (kind == 0) begin
                if ($urandom_range(0, 1)) push_byte(rand_separator());
                push_byte(CH_NEWLINE);
            end else begin
                repeat ($urandom_range(1, 3)) push_byte(rand_separator());
                push_byte(rand_letter());
                repeat (vlen - 1) push_byte(rand_ident_char());
                if ($urandom_range(0, 2) == 0) begin
                    push_byte(rand_separator());
                    repeat ($urandom_range(0, 3)) push_byte(CH_W'($urandom_range(0, 255)));
                end
                push_byte(CH_NEWLINE);
            end
        end
    endtask

    task automatic push_file(input int n, input int lim);
        int start;
        start = bytes_pushed;
        mark_first = 1'b1;
        while (bytes_pushed - start < n) begin
            if ($urandom_range(0, 9) == 0) push_byte(CH_W'($urandom_range(0, 255)));
            else push_line(lim);
        end
    endtask

    task automatic push_random_files(input int total, input int lim);
        int start;
        start = bytes_pushed;
        while (bytes_pushed - start < total) push_file($urandom_range(10, 50), lim);
    endtask

    // block drained: nothing queued, nothing on the wire, nothing owed
    task automatic wait_idle();
        do @(posedge aclk);
        while (bytes_to_send.size() != 0 || s_valid || scan_results_due.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    // register write with junk in the upper bits, then read back
    task automatic write_max_symbol(input logic [CFG_W-1:0] v);
        logic [APB_W-1:0] word;
        word = $urandom;
        word[CFG_W-1:0] = v;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_SYMBOL_LENGTH, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        max_symbol_limit = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        psel <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[CFG_W-1:0] !== v)
            flag_failure($sformatf("max_symbol_length read %0d, wrote %0d",
                                   prdata[CFG_W-1:0], v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stimulus sequence
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limit: byte extremes, every symbol class, missing values, one entry
        mark_first = 1'b1;
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("Az_09 \na Z\nk\n");
        wait_idle();

        // limit of one: key too long, halted bytes, restart, value too long
        write_max_symbol(10'd1);
        mark_first = 1'b1;
        push_text("ab c\nx");
        mark_first = 1'b1;
        push_text("a bc\n");
        wait_idle();

        write_max_symbol(10'd3);
        push_random_files(100, 3);
        wait_idle();

        write_max_symbol(10'd1);
        push_random_files(80, 1);
        wait_idle();

        write_max_symbol(CFG_W'($urandom_range(2, 20)));
        push_random_files(100, int'(max_symbol_limit));
        wait_idle();

        // widest limit: one long file with no restarts, so it runs into the end of the buffer
        write_max_symbol(10'd1023);
        restarts_on = 1'b0;
        push_file(1040, 1023);
        wait_idle();

        repeat (5) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: rename_map_line_tokenizer_unit.f
rtl/rmlt_pkg.sv
rtl/rename_map_line_tokenizer_unit.sv
bench/rename_map_line_tokenizer_unit_test.sv
